// File: rtl/core/ile_pkg.sv
// ile_pkg: shared constants, command codes, FSM state and request/result types
// for the indexed list engine. No dependencies.
package ile_pkg;

  // List capacity and derived widths
  localparam int CAPACITY = 32;
  localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int POS_W    = 6;
  localparam int CMP_W    = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int DATA_W   = 32;

  // Command codes
  localparam logic [2:0] CMD_READ   = 3'd0;
  localparam logic [2:0] CMD_FRONT  = 3'd1;
  localparam logic [2:0] CMD_APPEND = 3'd2;
  localparam logic [2:0] CMD_REMOVE = 3'd3;
  localparam logic [2:0] CMD_DUMP   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT,
    ST_SHIFT_UP,
    ST_FRONT_PUT,
    ST_SHIFT_DN,
    ST_DUMP
  } state_t;

  typedef struct packed {
    logic [2:0]              command;
    logic [POS_W-1:0]        position;
    logic signed [DATA_W-1:0] data_in;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic                     ok;
    logic                     last;
  } out_rsp_t;

endpackage

// File: rtl/core/indexed_list_engine.sv
// indexed_list_engine: ordered list of signed 32-bit values in one synchronous
// memory, with read, front insert, append, remove and dump commands.
// Depends on ile_pkg.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall   | in_req  (command, position, data_in)
//   out     | output    | out_valid / out_stall | out_rsp (data_out, ok, last)
//
// One request at a time; in_stall is low only in the idle state.
// Read, append, empty-list front insert and rejected commands go straight
// to the result. Front insert shifts every entry up, then writes the front;
// remove before the tail shifts later entries down; dump streams all entries.
// One write and one registered read port; shifts move one entry per cycle.
// Output stalls stretch each result-producing cycle by the stall length.
// rst_n (synchronous) empties the list; memory contents are not cleared.
module indexed_list_engine
  import ile_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_rsp_t out_rsp
);

  // Element store
  logic signed [DATA_W-1:0] mem [CAPACITY];
  logic                     wr_en, rd_en;
  logic [AW-1:0]            wr_addr, rd_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic signed [DATA_W-1:0] rd_q;

  // Control and pending result
  state_t                   state_r, state_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic                     res_ok_r, res_ok_nxt;
  logic                     res_mem_r, res_mem_nxt;
  logic                     res_neg_r, res_neg_nxt;

  // Output register
  logic                     out_valid_r, out_valid_nxt;
  out_rsp_t                 out_rsp_r, out_rsp_nxt;
  logic                     out_free, out_load;

  // Decode helpers
  logic                     accept;
  logic                     full;
  logic                     pos_in_range;
  logic                     pos_is_tail;
  logic                     dn_more;
  logic                     dump_last;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign full     = (cnt_r >= CW'(CAPACITY));

  assign pos_in_range = CMP_W'(in_req.position) < CMP_W'(cnt_r);
  assign pos_is_tail  = (CMP_W'(in_req.position) + CMP_W'(1)) == CMP_W'(cnt_r);
  assign dn_more      = ((CW+1)'(idx_r) + (CW+1)'(2)) < (CW+1)'(cnt_r);
  assign dump_last    = ((CW+1)'(idx_r) + (CW+1)'(1)) == (CW+1)'(cnt_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EMIT;
          unique case (in_req.command)
            CMD_FRONT:  if (!full && cnt_r != '0) state_nxt = ST_SHIFT_UP;
            CMD_REMOVE: if (pos_in_range && !pos_is_tail) state_nxt = ST_SHIFT_DN;
            CMD_DUMP:   if (cnt_r != '0) state_nxt = ST_DUMP;
            default:    state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_EMIT:      if (out_free) state_nxt = ST_IDLE;
      ST_SHIFT_UP:  if (idx_r == AW'(1)) state_nxt = ST_FRONT_PUT;
      ST_FRONT_PUT: state_nxt = ST_EMIT;
      ST_SHIFT_DN:  if (!dn_more) state_nxt = ST_EMIT;
      ST_DUMP:      if (out_free && dump_last) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    in_stall    = (state_r != ST_IDLE);
    wr_en       = 1'b0;
    wr_addr     = idx_r;
    wr_data     = rd_q;
    rd_en       = 1'b0;
    rd_addr     = idx_r;
    idx_nxt     = idx_r;
    cnt_nxt     = cnt_r;
    val_nxt     = val_r;
    res_ok_nxt  = res_ok_r;
    res_mem_nxt = res_mem_r;
    res_neg_nxt = res_neg_r;
    out_load    = 1'b0;
    out_rsp_nxt = out_rsp_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_ok_nxt  = 1'b0;
          res_mem_nxt = 1'b0;
          res_neg_nxt = 1'b0;
          val_nxt     = in_req.data_in;
          unique case (in_req.command)
            CMD_READ: begin
              if (pos_in_range) begin
                rd_en       = 1'b1;
                rd_addr     = AW'(in_req.position);
                res_ok_nxt  = 1'b1;
                res_mem_nxt = 1'b1;
              end else begin
                res_neg_nxt = 1'b1;
              end
            end
            CMD_FRONT: begin
              if (!full) begin
                if (cnt_r == '0) begin
                  // empty list: place directly at the front
                  wr_en      = 1'b1;
                  wr_addr    = '0;
                  wr_data    = in_req.data_in;
                  cnt_nxt    = cnt_r + CW'(1);
                  res_ok_nxt = 1'b1;
                end else begin
                  // start shifting from the tail downward
                  idx_nxt = AW'(cnt_r);
                  rd_en   = 1'b1;
                  rd_addr = AW'(cnt_r - CW'(1));
                end
              end
            end
            CMD_APPEND: begin
              if (!full) begin
                wr_en      = 1'b1;
                wr_addr    = AW'(cnt_r);
                wr_data    = in_req.data_in;
                cnt_nxt    = cnt_r + CW'(1);
                res_ok_nxt = 1'b1;
              end
            end
            CMD_REMOVE: begin
              if (pos_in_range) begin
                if (pos_is_tail) begin
                  cnt_nxt    = cnt_r - CW'(1);
                  res_ok_nxt = 1'b1;
                end else begin
                  idx_nxt = AW'(in_req.position);
                  rd_en   = 1'b1;
                  rd_addr = AW'(in_req.position) + AW'(1);
                end
              end
            end
            CMD_DUMP: begin
              if (cnt_r != '0) begin
                idx_nxt = '0;
                rd_en   = 1'b1;
                rd_addr = '0;
              end
            end
            default: ;
          endcase
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_rsp_nxt.ok       = res_ok_r;
          out_rsp_nxt.last     = 1'b1;
          if (res_mem_r) begin
            out_rsp_nxt.data_out = rd_q;
          end else if (res_neg_r) begin
            out_rsp_nxt.data_out = -32'sd1;
          end else begin
            out_rsp_nxt.data_out = '0;
          end
        end
      end

      // move entry idx-1 up into idx, fetch the next one below
      ST_SHIFT_UP: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = rd_q;
        if (idx_r != AW'(1)) begin
          rd_en   = 1'b1;
          rd_addr = idx_r - AW'(2);
        end
        idx_nxt = idx_r - AW'(1);
      end

      ST_FRONT_PUT: begin
        wr_en      = 1'b1;
        wr_addr    = '0;
        wr_data    = val_r;
        cnt_nxt    = cnt_r + CW'(1);
        res_ok_nxt = 1'b1;
      end

      // move entry idx+1 down into idx, fetch idx+2 if still in the list
      ST_SHIFT_DN: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = rd_q;
        if (dn_more) begin
          rd_en   = 1'b1;
          rd_addr = idx_r + AW'(2);
          idx_nxt = idx_r + AW'(1);
        end else begin
          cnt_nxt    = cnt_r - CW'(1);
          res_ok_nxt = 1'b1;
        end
      end

      // stream entries out, one per free output slot
      ST_DUMP: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_rsp_nxt.data_out = rd_q;
          out_rsp_nxt.ok       = 1'b1;
          out_rsp_nxt.last     = dump_last;
          if (!dump_last) begin
            rd_en   = 1'b1;
            rd_addr = idx_r + AW'(1);
            idx_nxt = idx_r + AW'(1);
          end
        end
      end

      default: ;
    endcase
  end

  // Output valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    val_r     <= val_nxt;
    res_ok_r  <= res_ok_nxt;
    res_mem_r <= res_mem_nxt;
    res_neg_r <= res_neg_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  // Element memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (cnt_r != $past(cnt_r)) |->
      (cnt_r == $past(cnt_r) + CW'(1)) || (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("entry count moved by more than one");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while stalled");

  a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write hit the same entry");

endmodule
